FILE: rtl/core/hwaf_pkg.sv
// ----------------------------------------------------------------------------
// hwaf_pkg
// Shared constants for the history window average filter.
// ----------------------------------------------------------------------------
`default_nettype none

package hwaf_pkg;

    localparam int DEPTH_DEF       = 8;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int VALUE_W    = 16;
    localparam int CNT_W      = 4;
    localparam int TAP_W      = 3;
    localparam int WEIGHT_W   = 16;
    localparam int FRAC_W     = 14;
    localparam int NUM_TAPS   = 8;
    localparam int DIV_STEPS  = 16;
    localparam int REM_W      = 3;
    localparam int STEP_CNT_W = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_HIGH  = 2'd3;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic                  MODE_RESET    = 1'b0;
    localparam logic [CNT_W-1:0]      WINDOW_RESET  = 4'd8;
    localparam logic [CFG_DATA_W-1:0] WEIGHTS_RESET = 64'h4000_4000_4000_4000;

    localparam logic [VALUE_W-1:0] VALUE_POS_MAX = 16'h7FFF;
    localparam logic [VALUE_W-1:0] VALUE_NEG_MAX = 16'h8000;

endpackage

`default_nettype wire

FILE: rtl/core/hwaf_if.sv
// ----------------------------------------------------------------------------
// hwaf_if
// Valid/ready channels for filter commands and filter results.
// ----------------------------------------------------------------------------
`default_nettype none

interface hwaf_in_if import hwaf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output command, output sample, input ready);
    modport sink   (input valid, input command, input sample, output ready);
endinterface

interface hwaf_out_if import hwaf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] filtered_value;
    logic        [CNT_W-1:0]   held_count;
    logic                      saturated;

    modport source (output valid, output filtered_value, output held_count,
                    output saturated, input ready);
    modport sink   (input valid, input filtered_value, input held_count,
                    input saturated, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hwaf_ram.sv
// ----------------------------------------------------------------------------
// hwaf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hwaf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/history_window_average_filter.sv
// ----------------------------------------------------------------------------
// history_window_average_filter
// Mean or weighted mean over the newest samples of a circular history RAM.
// ----------------------------------------------------------------------------
// A push reads the history RAM once per tap of the effective window n, then
// divides in the 16-step serial divider; a quotient that overflows 16 bits
// skips the divider. One transaction in work at a time; the next is taken
// once the result is parked. Reset (async, active low) empties the history
// and loads defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module history_window_average_filter import hwaf_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    hwaf_in_if.sink                    in_ch,
    hwaf_out_if.source                 out_ch
);

    localparam int AW     = $clog2(DEPTH);
    localparam int PROD_W = SAMPLE_BITS + WEIGHT_W;
    localparam int ACC_W  = PROD_W + TAP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_ABS,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

    state_t                    state_reg, state_next;
    logic [AW-1:0]             wp_reg, wp_next;
    logic                      full_reg, full_next;
    logic                      mode_reg, mode_next;
    logic [CNT_W-1:0]          window_reg, window_next;
    logic [CFG_DATA_W-1:0]     wlo_reg, wlo_next;
    logic [CFG_DATA_W-1:0]     whi_reg, whi_next;
    logic [AW-1:0]             rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]          issue_cnt_reg, issue_cnt_next;
    logic                      rd_valid_reg, rd_valid_next;
    logic [TAP_W-1:0]          mul_tap_reg, mul_tap_next;
    logic                      prod_valid_reg, prod_valid_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [CNT_W-1:0]          held_reg, held_next;
    logic                      neg_reg, neg_next;
    logic [VALUE_W-1:0]        dvd_reg, dvd_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [STEP_CNT_W-1:0]     step_reg, step_next;
    logic [VALUE_W-1:0]        res_value_reg, res_value_next;
    logic                      res_sat_reg, res_sat_next;
    logic                      out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]        out_value_reg, out_value_next;
    logic [CNT_W-1:0]          out_held_reg, out_held_next;
    logic                      out_sat_reg, out_sat_next;

    logic                      in_accept;
    logic                      wr_en;
    logic                      issuing;
    logic signed [SAMPLE_BITS-1:0] ram_rdata;
    logic [AW-1:0]             wp_inc;
    logic                      wp_wrap;
    logic [CNT_W-1:0]          held_new;
    logic [CNT_W-1:0]          win_a, win_b, n_new;
    logic [2*CFG_DATA_W-1:0]   w_all;
    logic signed [WEIGHT_W-1:0] tap_w;
    logic signed [PROD_W-1:0]  prod_mul;
    logic signed [ACC_W-1:0]   acc_sum;
    logic [ACC_W-1:0]          acc_abs, mag, n_limit;
    logic                      sat_big;
    logic [REM_W:0]            rem_sh, rem_sub;
    logic                      rem_ge;

    hwaf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (in_ch.sample),
        .rd_en   (issuing),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rdata)
    );

    assign in_ch.ready           = (state_reg == S_IDLE);
    assign in_accept             = in_ch.valid && in_ch.ready;
    assign wr_en                 = in_accept && (in_ch.command == CMD_PUSH);
    assign issuing               = (state_reg == S_MAC) && (issue_cnt_reg != n_reg);

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.filtered_value = out_value_reg;
    assign out_ch.held_count     = out_held_reg;
    assign out_ch.saturated      = out_sat_reg;

    // window after this push
    assign wp_wrap  = (wp_reg == AW'(DEPTH - 1));
    assign wp_inc   = wp_wrap ? '0 : wp_reg + 1'b1;
    assign held_new = (wp_wrap || full_reg) ? CNT_W'(DEPTH) : CNT_W'(wp_reg) + 1'b1;
    assign win_a    = (window_reg == '0) ? CNT_W'(1) : window_reg;
    assign win_b    = (win_a > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : win_a;
    assign n_new    = (win_b > held_new) ? held_new : win_b;

    assign w_all    = {whi_reg, wlo_reg};
    assign tap_w    = w_all[int'(mul_tap_reg) * WEIGHT_W +: WEIGHT_W];
    assign prod_mul = PROD_W'(ram_rdata) * PROD_W'(tap_w);
    assign acc_sum  = acc_reg + ACC_W'(prod_reg);

    assign acc_abs  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign mag      = mode_reg ? (acc_abs >> FRAC_W) : acc_abs;
    assign n_limit  = ACC_W'(n_reg) << DIV_STEPS;
    assign sat_big  = (mag >= n_limit);

    assign rem_sh   = {rem_reg, dvd_reg[VALUE_W-1]};
    assign rem_ge   = (rem_sh >= n_reg);
    assign rem_sub  = rem_sh - n_reg;

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        full_next       = full_reg;
        mode_next       = mode_reg;
        window_next     = window_reg;
        wlo_next        = wlo_reg;
        whi_next        = whi_reg;
        rd_ptr_next     = rd_ptr_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_valid_next   = 1'b0;
        mul_tap_next    = mul_tap_reg;
        prod_valid_next = 1'b0;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        n_next          = n_reg;
        held_next       = held_reg;
        neg_next        = neg_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        res_value_next  = res_value_reg;
        res_sat_next    = res_sat_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_value_next  = out_value_reg;
        out_held_next   = out_held_reg;
        out_sat_next    = out_sat_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FILTER_MODE:   mode_next   = cfg_data[0];
                CFG_WINDOW_LENGTH: window_next = cfg_data[CNT_W-1:0];
                CFG_WEIGHTS_LOW:   wlo_next    = cfg_data;
                CFG_WEIGHTS_HIGH:  whi_next    = cfg_data;
                default:           mode_next   = mode_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_ch.command == CMD_FLUSH)
                    begin
                        wp_next        = '0;
                        full_next      = 1'b0;
                        held_next      = '0;
                        res_value_next = '0;
                        res_sat_next   = 1'b0;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        wp_next        = wp_inc;
                        full_next      = full_reg || wp_wrap;
                        held_next      = held_new;
                        n_next         = n_new;
                        rd_ptr_next    = wp_reg;
                        issue_cnt_next = '0;
                        mul_tap_next   = '0;
                        acc_next       = '0;
                        state_next     = S_MAC;
                    end
                end
            end
            S_MAC:
            begin
                if (issuing)
                begin
                    rd_ptr_next    = (rd_ptr_reg == '0) ? AW'(DEPTH - 1) : rd_ptr_reg - 1'b1;
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                rd_valid_next = issuing;
                if (rd_valid_reg)
                begin
                    prod_next    = mode_reg ? prod_mul : PROD_W'(ram_rdata);
                    mul_tap_next = mul_tap_reg + 1'b1;
                end
                prod_valid_next = rd_valid_reg;
                if (prod_valid_reg)
                begin
                    acc_next = acc_sum;
                end
                if (!issuing && !rd_valid_reg && !prod_valid_reg)
                begin
                    state_next = S_ABS;
                end
            end
            S_ABS:
            begin
                neg_next = acc_reg[ACC_W-1];
                if (sat_big)
                begin
                    res_sat_next   = 1'b1;
                    res_value_next = acc_reg[ACC_W-1] ? VALUE_NEG_MAX : VALUE_POS_MAX;
                    state_next     = S_OUT;
                end
                else
                begin
                    rem_next   = mag[DIV_STEPS +: REM_W];
                    dvd_next   = mag[VALUE_W-1:0];
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = rem_ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
                dvd_next  = {dvd_reg[VALUE_W-2:0], rem_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (neg_reg)
                begin
                    res_sat_next   = (dvd_reg > VALUE_NEG_MAX);
                    res_value_next = (dvd_reg > VALUE_NEG_MAX) ? VALUE_NEG_MAX : -dvd_reg;
                end
                else
                begin
                    res_sat_next   = (dvd_reg > VALUE_POS_MAX);
                    res_value_next = (dvd_reg > VALUE_POS_MAX) ? VALUE_POS_MAX : dvd_reg;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_held_next  = held_reg;
                    out_sat_next   = res_sat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wp_reg         <= '0;
            full_reg       <= 1'b0;
            mode_reg       <= MODE_RESET;
            window_reg     <= WINDOW_RESET;
            wlo_reg        <= WEIGHTS_RESET;
            whi_reg        <= WEIGHTS_RESET;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            issue_cnt_reg  <= '0;
            n_reg          <= '0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            full_reg       <= full_next;
            mode_reg       <= mode_next;
            window_reg     <= window_next;
            wlo_reg        <= wlo_next;
            whi_reg        <= whi_next;
            rd_valid_reg   <= rd_valid_next;
            prod_valid_reg <= prod_valid_next;
            issue_cnt_reg  <= issue_cnt_next;
            n_reg          <= n_next;
            held_reg       <= held_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg    <= rd_ptr_next;
        mul_tap_reg   <= mul_tap_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        neg_reg       <= neg_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        step_reg      <= step_next;
        res_value_reg <= res_value_next;
        res_sat_reg   <= res_sat_next;
        out_value_reg <= out_value_next;
        out_held_reg  <= out_held_next;
        out_sat_reg   <= out_sat_next;
    end

`ifndef ASSERT_OFF
    a_window_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> ((n_reg != '0) && (n_reg <= held_reg)))
        else $error("filter window outside held samples");

    a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.saturated) |->
        ((out_ch.filtered_value == VALUE_POS_MAX) || (out_ch.filtered_value == VALUE_NEG_MAX)))
        else $error("saturated result not at a limit");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.held_count <= CNT_W'(DEPTH)))
        else $error("held count beyond history depth");
`endif

endmodule

`default_nettype wire

FILE: dv/filter_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// filter_result_checker
// Watches the command, result and register ports of the filter, keeps its
// own copy of the sample history and settings, predicts every result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module filter_result_checker import hwaf_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    hwaf_in_if                         in_ch,
    hwaf_out_if                        out_ch,
    output int                         fail_count,
    output int                         pending
);

    localparam int DEPTH = DEPTH_DEF;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic        [CNT_W-1:0]   count;
        logic                      sat;
    } filter_result_t;

    logic signed [VALUE_W-1:0] history [DEPTH];
    logic        [TAP_W-1:0]   wr_ptr;
    logic                      hist_full;
    logic                      mode;
    logic        [CNT_W-1:0]   window;
    logic        [CFG_DATA_W-1:0] taps_lo;
    logic        [CFG_DATA_W-1:0] taps_hi;

    filter_result_t expected_results [$];

    task automatic report_mismatch(input string msg);
        if (fail_count < 100)
            $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    // Store the sample, then average or weight the newest n entries.
    function automatic filter_result_t filter_push(input logic signed [VALUE_W-1:0] smp);
        logic [2*CFG_DATA_W-1:0]    tap_words;
        logic signed [WEIGHT_W-1:0] tap_w;
        int                         held;
        int                         n;
        int                         slot;
        longint                     acc;
        longint                     den;
        longint                     quo;
        filter_result_t             res;
        history[wr_ptr] = smp;
        wr_ptr = wr_ptr + 1'b1;
        if (wr_ptr == '0)
            hist_full = 1'b1;
        held = hist_full ? DEPTH : int'(wr_ptr);
        n = (window == '0) ? 1 : int'(window);
        if (n > DEPTH)
            n = DEPTH;
        if (n > held)
            n = held;
        tap_words = {taps_hi, taps_lo};
        acc = 0;
        for (int i = 0; i < n; i++)
        begin
            slot = (int'(wr_ptr) + DEPTH - 1 - i) % DEPTH;
            tap_w = tap_words[WEIGHT_W*i +: WEIGHT_W];
            if (mode)
                acc += longint'(history[slot]) * longint'(tap_w);
            else
                acc += longint'(history[slot]);
        end
        den = mode ? (longint'(n) <<< FRAC_W) : longint'(n);
        quo = acc / den;
        res.sat = 1'b0;
        if (quo > 32767)
        begin
            quo = 32767;
            res.sat = 1'b1;
        end
        else if (quo < -32768)
        begin
            quo = -32768;
            res.sat = 1'b1;
        end
        res.value = quo[VALUE_W-1:0];
        res.count = held[CNT_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        filter_result_t exp_res;
        if (!rst_n)
        begin
            foreach (history[i])
                history[i] = '0;
            wr_ptr     = '0;
            hist_full  = 1'b0;
            mode       = MODE_RESET;
            window     = WINDOW_RESET;
            taps_lo    = WEIGHTS_RESET;
            taps_hi    = WEIGHTS_RESET;
            expected_results.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FILTER_MODE:   mode    = cfg_data[0];
                    CFG_WINDOW_LENGTH: window  = cfg_data[CNT_W-1:0];
                    CFG_WEIGHTS_LOW:   taps_lo = cfg_data;
                    CFG_WEIGHTS_HIGH:  taps_hi = cfg_data;
                    default: ;
                endcase
            end

            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.command == CMD_FLUSH)
                begin
                    foreach (history[i])
                        history[i] = '0;
                    wr_ptr    = '0;
                    hist_full = 1'b0;
                    expected_results.push_back('0);
                end
                else
                begin
                    expected_results.push_back(filter_push(in_ch.sample));
                end
            end

            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result transaction with no command outstanding");
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (out_ch.filtered_value !== exp_res.value)
                        report_mismatch($sformatf("filtered_value exp %0d got %0d",
                                                  exp_res.value, out_ch.filtered_value));
                    if (out_ch.held_count !== exp_res.count)
                        report_mismatch($sformatf("held_count exp %0d got %0d",
                                                  exp_res.count, out_ch.held_count));
                    if (out_ch.saturated !== exp_res.sat)
                        report_mismatch($sformatf("saturated exp %0b got %0b",
                                                  exp_res.sat, out_ch.saturated));
                end
            end

            pending = expected_results.size();
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the history window average filter with directed corner cases and
// random push/flush traffic over many register settings, with random gaps
// and output stalls; a checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench import hwaf_pkg::*; ();

    localparam logic MODE_PLAIN    = 1'b0;
    localparam logic MODE_WEIGHTED = 1'b1;

    localparam int NUM_SETTINGS     = 24;
    localparam int ITEMS_PER_SET    = 80;
    localparam int LONG_HOLD_CYCLES = 400;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int push_total;
    int flush_total;
    int setting_total;
    bit no_idle;
    bit hold_request;

    hwaf_in_if  in_ch ();
    hwaf_out_if out_ch ();

    history_window_average_filter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    filter_result_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 clk = ~clk;

    // Mostly short idle stretches, a few long ones.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 20);
        else
            return $urandom_range(30, 100);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_sample();
        logic [VALUE_W-1:0] corner [5];
        corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
        if ($urandom_range(0, 9) == 0)
            return corner[$urandom_range(0, 4)];
        return VALUE_W'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_weights();
        logic [CFG_DATA_W-1:0] word;
        int                    r;
        for (int i = 0; i < 4; i++)
        begin
            r = $urandom_range(0, 5);
            case (r)
                0:       word[16*i +: 16] = 16'h7FFF;
                1:       word[16*i +: 16] = 16'h8000;
                2:       word[16*i +: 16] = 16'h0000;
                3:       word[16*i +: 16] = 16'h4000;
                4:       word[16*i +: 16] = 16'hFFFF;
                default: word[16*i +: 16] = 16'($urandom);
            endcase
        end
        return word;
    endfunction

    function automatic logic [CNT_W-1:0] pick_window();
        case ($urandom_range(0, 9))
            0:       return 4'd0;
            1:       return 4'd15;
            2:       return 4'd1;
            3:       return 4'd8;
            default: return CNT_W'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [VALUE_W-1:0] smp);
        int gap;
        gap = no_idle ? 0 : idle_length();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.sample  <= smp;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (cmd == CMD_FLUSH)
            flush_total++;
        else
            push_total++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic mode, input logic [CNT_W-1:0] window,
                                  input logic [CFG_DATA_W-1:0] taps_lo,
                                  input logic [CFG_DATA_W-1:0] taps_hi);
        write_reg(CFG_FILTER_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
        write_reg(CFG_WINDOW_LENGTH, {{(CFG_DATA_W-CNT_W){1'b0}}, window});
        write_reg(CFG_WEIGHTS_LOW, taps_lo);
        write_reg(CFG_WEIGHTS_HIGH, taps_hi);
        cfg_we <= 1'b0;
        setting_total++;
    endtask

    // Output side: random ready runs, an occasional long hold on request.
    initial
    begin
        int run_left;
        bit rdy_val;
        run_left     = 0;
        rdy_val      = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rdy_val      = 1'b0;
                run_left     = LONG_HOLD_CYCLES;
            end
            else if (run_left <= 0)
            begin
                if (no_idle)
                begin
                    rdy_val  = 1'b1;
                    run_left = 1;
                end
                else if ($urandom_range(0, 99) < 70)
                begin
                    rdy_val  = 1'b1;
                    run_left = $urandom_range(1, 16);
                end
                else
                begin
                    rdy_val  = 1'b0;
                    run_left = idle_length() + 1;
                end
            end
            out_ch.ready <= rdy_val;
            run_left--;
        end
    end

    initial
    begin
        #100_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        push_total    = 0;
        flush_total   = 0;
        setting_total = 0;
        no_idle       = 1'b0;
        hold_request  = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_PUSH;
        in_ch.sample  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: flush on empty history, extremes, truncation.
        send_item(CMD_FLUSH, 16'h1234);
        send_item(CMD_PUSH, 16'h7FFF);
        send_item(CMD_PUSH, 16'h8000);
        send_item(CMD_PUSH, 16'h0001);
        send_item(CMD_PUSH, 16'hFFFF);
        wait_drained();

        // Weighted, window above depth, max/min weights, history wrap.
        apply_settings(MODE_WEIGHTED, 4'd15, {4{16'h7FFF}}, {4{16'h8000}});
        repeat (4) send_item(CMD_PUSH, 16'h7FFF);
        repeat (2) send_item(CMD_PUSH, 16'h8000);
        wait_drained();

        // Zero window acts as one, flush then refill.
        apply_settings(MODE_PLAIN, 4'd0, '0, '1);
        send_item(CMD_PUSH, 16'h8000);
        send_item(CMD_PUSH, 16'h7FFF);
        send_item(CMD_FLUSH, 16'hFFFF);
        send_item(CMD_PUSH, 16'h0005);
        wait_drained();

        // Single tap at -2.0: saturation both ways.
        apply_settings(MODE_WEIGHTED, 4'd1, {4{16'h8000}}, WEIGHTS_RESET);
        send_item(CMD_PUSH, 16'h8000);
        send_item(CMD_PUSH, 16'h7FFF);
        send_item(CMD_PUSH, 16'h3039);
        wait_drained();

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            no_idle = (p == 2) || (p == 9);
            apply_settings(logic'($urandom_range(0, 1)), pick_window(),
                           pick_weights(), pick_weights());
            if (p == 2)
                hold_request = 1'b1;
            for (int k = 0; k < ITEMS_PER_SET; k++)
            begin
                if ($urandom_range(0, 99) < 4)
                    send_item(CMD_FLUSH, pick_sample());
                else
                    send_item(CMD_PUSH, pick_sample());
            end
            wait_drained();
        end

        no_idle = 1'b0;
        repeat (40) @(posedge clk);

        $display("Covered %0d pushes and %0d flushes over %0d register settings,",
                 push_total, flush_total, setting_total);
        $display("incl. saturation, window clamping, history wrap and a long output hold.");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/hwaf_pkg.sv
rtl/core/hwaf_if.sv
rtl/core/hwaf_ram.sv
rtl/core/history_window_average_filter.sv
dv/filter_result_checker.sv
dv/testbench.sv
